/* hw/rtl/psv_pkg.sv */
// psv_pkg: shared types and constants for the plucked string voice
// no dependencies; used by every other file of the block except psv_ram

package psv_pkg;

    localparam int OP_W        = 1;
    localparam int SAMPLE_W    = 16;
    localparam int LEN_W       = 13;
    localparam int GAIN_W      = 16;
    localparam int ATTACK_W    = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int MUL_W       = 18;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = PROD_W - 16;
    localparam int DIV_CNT_W   = 4;

    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_TICK = 1'b1;

    localparam logic [LEN_W-1:0]    LEN_RESET    = 13'd100;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd65274;
    localparam logic [ATTACK_W-1:0] ATTACK_RESET = 12'd220;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STRING_LENGTH = 2'd0,
        REG_DECAY_GAIN    = 2'd1,
        REG_ATTACK_LENGTH = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD_CUR,
        ST_RD_NXT,
        ST_MUL_RAMP,
        ST_MUL_DECAY,
        ST_MUL_PREV,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic take;
        logic load_write;
        logic rd_cur;
        logic rd_nxt;
        logic mul_ramp;
        logic mul_decay;
        logic mul_prev;
        logic div_step;
        logic finish;
    } psv_cmd_t;

    typedef struct packed {
        logic req_valid;
        logic req_tick;
        logic ramp_active;
        logic div_last;
        logic out_busy;
    } psv_status_t;

endpackage

/* hw/rtl/psv_item_if.sv */
// psv_item_if: request channel carrying load and tick requests
// depends on psv_pkg for field widths

interface psv_item_if;
    logic                                valid;
    logic                                ready;
    logic        [psv_pkg::OP_W-1:0]     operation;
    logic signed [psv_pkg::SAMPLE_W-1:0] noise_value;

    modport source (output valid, output operation, output noise_value, input ready);
    modport sink   (input valid, input operation, input noise_value, output ready);
endinterface

/* hw/rtl/psv_result_if.sv */
// psv_result_if: result channel carrying output audio samples
// depends on psv_pkg for field widths

interface psv_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [psv_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* hw/rtl/psv_cfg_if.sv */
// psv_cfg_if: configuration write channel, register index and data
// depends on psv_pkg for field widths

interface psv_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [psv_pkg::CFG_IDX_W-1:0]     index;
    logic [psv_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/plucked_string_voice_top.sv */
// plucked_string_voice_top: karplus-strong voice, controller plus datapath
// depends on psv_pkg, the three channel interfaces, psv_controller and psv_datapath
//
// usage
// - cfg: register writes (0 string_length, 1 decay_gain, 2 attack_length), always
//   ready; write only while no request is in flight
// - item: operation 0 loads noise_value at the fill position and restarts the
//   pluck, operation 1 is a tick; ready is high only while the sequencer is idle
// - result: one sample per tick, none per load, held in an output register
// - a load writes noise_value into the delay line and then returns to idle
// - a tick reads two delay line samples, runs the shared multiplier for ramp,
//   decay and previous sample, and while the attack ramp runs also steps the one
//   bit per cycle ramp divider before it finishes
// - a tick finishes only once the previous result has been taken, so a stalled
//   receiver holds the block in its last step with nothing lost
// - reset clears positions, filter state, ramp count and result valid, and loads
//   the register defaults 100, 65274 and 220; delay line contents are not
//   cleared, so load string_length samples before the first tick

module plucked_string_voice_top #(
    parameter int MAX_LENGTH = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    psv_item_if.sink      item,
    psv_result_if.source  result,
    psv_cfg_if.sink       cfg
);

    psv_pkg::psv_cmd_t    cmd;
    psv_pkg::psv_status_t status;

    psv_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    psv_datapath #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_valid     (item.valid),
        .req_operation (item.operation),
        .req_noise     (item.noise_value),
        .cfg_valid     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .out_sample    (result.sample)
    );

    assign item.ready = cmd.take;
    assign cfg.ready  = 1'b1;

endmodule

/* hw/rtl/psv_ram.sv */
// psv_ram: generic single write port, single read port ram with registered read
// no dependencies

module psv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/psv_controller.sv */
// psv_controller: sequencing state machine for load and tick requests
// depends on psv_pkg for state, command and status types

module psv_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psv_pkg::psv_status_t  status,
    output psv_pkg::psv_cmd_t     cmd
);

    psv_pkg::state_t state_reg;
    psv_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            psv_pkg::ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (status.req_valid)
                begin
                    state_next = status.req_tick ? psv_pkg::ST_RD_CUR : psv_pkg::ST_LOAD;
                end
            end
            psv_pkg::ST_LOAD:
            begin
                cmd.load_write = 1'b1;
                state_next     = psv_pkg::ST_IDLE;
            end
            psv_pkg::ST_RD_CUR:
            begin
                cmd.rd_cur = 1'b1;
                state_next = psv_pkg::ST_RD_NXT;
            end
            psv_pkg::ST_RD_NXT:
            begin
                cmd.rd_nxt = 1'b1;
                state_next = psv_pkg::ST_MUL_RAMP;
            end
            psv_pkg::ST_MUL_RAMP:
            begin
                cmd.mul_ramp = 1'b1;
                state_next   = psv_pkg::ST_MUL_DECAY;
            end
            psv_pkg::ST_MUL_DECAY:
            begin
                cmd.mul_decay = 1'b1;
                state_next    = psv_pkg::ST_MUL_PREV;
            end
            psv_pkg::ST_MUL_PREV:
            begin
                cmd.mul_prev = 1'b1;
                state_next   = status.ramp_active ? psv_pkg::ST_DIVIDE : psv_pkg::ST_FINISH;
            end
            psv_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = psv_pkg::ST_FINISH;
                end
            end
            psv_pkg::ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = psv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psv_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/psv_datapath.sv */
// psv_datapath: config registers, string state, shared multiplier, ramp divider
// depends on psv_pkg and psv_ram

module psv_datapath #(
    parameter int MAX_LENGTH = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  psv_pkg::psv_cmd_t                     cmd,
    output psv_pkg::psv_status_t                  status,
    input  logic                                  req_valid,
    input  logic        [psv_pkg::OP_W-1:0]       req_operation,
    input  logic signed [psv_pkg::SAMPLE_W-1:0]   req_noise,
    input  logic                                  cfg_valid,
    input  logic        [psv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [psv_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [psv_pkg::SAMPLE_W-1:0]   out_sample
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int CW = (AW + 1 > psv_pkg::LEN_W) ? AW + 1 : psv_pkg::LEN_W;
    localparam logic [CW-1:0] MAX_LEN_C = CW'(MAX_LENGTH);
    localparam logic [CW-1:0] MIN_LEN_C = CW'(2);
    localparam int SW = psv_pkg::SAMPLE_W;
    localparam int MW = psv_pkg::MUL_W;
    localparam int PW = psv_pkg::PROD_W;
    localparam int XW = psv_pkg::ACC_W;
    localparam int TW = psv_pkg::ATTACK_W;

    // configuration
    logic [psv_pkg::LEN_W-1:0]  string_length_reg;
    logic [psv_pkg::GAIN_W-1:0] decay_gain_reg;
    logic [TW-1:0]              attack_length_reg;

    // string state
    logic [AW-1:0]        read_pos_reg;
    logic [AW-1:0]        fill_pos_reg;
    logic signed [SW-1:0] prev_reg;
    logic [TW-1:0]        ramp_reg;

    // per request working registers
    logic signed [SW-1:0] noise_reg;
    logic [AW-1:0]        r_reg;
    logic [AW-1:0]        rn_reg;
    logic signed [SW-1:0] cur_reg;
    logic signed [SW-1:0] avg_reg;
    logic signed [XW-1:0] acc_reg;
    logic signed [SW-1:0] new_reg;
    logic [TW-1:0]        rem_reg;
    logic [SW-1:0]        quo_reg;
    logic [psv_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic                 out_valid_reg;
    logic signed [SW-1:0] out_sample_reg;

    logic [CW-1:0]        eff_len;
    logic [CW-1:0]        len_ext;
    logic [AW-1:0]        r_pos;
    logic [AW-1:0]        rn_pos;
    logic [CW-1:0]        r_plus;
    logic [AW-1:0]        f_pos;
    logic [AW-1:0]        f_next;
    logic [CW-1:0]        f_plus;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [SW-1:0]        ram_rdata;

    logic [SW-1:0]        cur_mag;
    logic [SW:0]          decay_comp;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [SW:0]   pair_sum;
    logic signed [XW:0]   filt_sum;
    logic signed [SW-1:0] filt_sat;
    logic [TW:0]          div_trial;
    logic [TW:0]          div_diff;
    logic                 div_ge;
    logic                 ramp_active;
    logic signed [SW-1:0] ramp_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            string_length_reg <= psv_pkg::LEN_RESET;
            decay_gain_reg    <= psv_pkg::GAIN_RESET;
            attack_length_reg <= psv_pkg::ATTACK_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                psv_pkg::REG_STRING_LENGTH: string_length_reg <= cfg_data[psv_pkg::LEN_W-1:0];
                psv_pkg::REG_DECAY_GAIN:    decay_gain_reg    <= cfg_data[psv_pkg::GAIN_W-1:0];
                psv_pkg::REG_ATTACK_LENGTH: attack_length_reg <= cfg_data[TW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // effective length and wrapped positions
    always_comb
    begin
        len_ext = CW'(string_length_reg);
        if (len_ext < MIN_LEN_C)
        begin
            eff_len = MIN_LEN_C;
        end
        else if (len_ext > MAX_LEN_C)
        begin
            eff_len = MAX_LEN_C;
        end
        else
        begin
            eff_len = len_ext;
        end
        r_pos  = (CW'(read_pos_reg) < eff_len) ? read_pos_reg : '0;
        r_plus = CW'(r_pos) + CW'(1);
        rn_pos = (r_plus >= eff_len) ? '0 : r_plus[AW-1:0];
        f_pos  = (CW'(fill_pos_reg) < eff_len) ? fill_pos_reg : '0;
        f_plus = CW'(f_pos) + CW'(1);
        f_next = (f_plus >= eff_len) ? '0 : f_plus[AW-1:0];
    end

    assign ram_we    = cmd.load_write | cmd.finish;
    assign ram_waddr = cmd.load_write ? f_pos : r_reg;
    assign ram_wdata = cmd.load_write ? noise_reg : new_reg;
    assign ram_raddr = cmd.rd_cur ? r_pos : rn_reg;

    psv_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_LENGTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared multiplier
    always_comb
    begin
        cur_mag    = cur_reg[SW-1] ? (~cur_reg + SW'(1)) : cur_reg;
        decay_comp = (SW+1)'(17'h10000) - (SW+1)'(decay_gain_reg);
        priority if (cmd.mul_ramp)
        begin
            mul_a = {2'b00, cur_mag};
            mul_b = {{(MW-TW){1'b0}}, ramp_reg};
        end
        else if (cmd.mul_decay)
        begin
            mul_a = {{2{avg_reg[SW-1]}}, avg_reg};
            mul_b = {2'b00, decay_gain_reg};
        end
        else
        begin
            mul_a = {{2{prev_reg[SW-1]}}, prev_reg};
            mul_b = {1'b0, decay_comp};
        end
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        pair_sum = {cur_reg[SW-1], cur_reg} + {ram_rdata[SW-1], ram_rdata};
        filt_sum = {acc_reg[XW-1], acc_reg} + {mul_p[PW-1], mul_p[PW-1:16]};
        if (filt_sum > (XW+1)'(32767))
        begin
            filt_sat = 16'sh7fff;
        end
        else if (filt_sum < -(XW+1)'(32768))
        begin
            filt_sat = 16'sh8000;
        end
        else
        begin
            filt_sat = filt_sum[SW-1:0];
        end
        div_trial   = {rem_reg, quo_reg[SW-1]};
        div_diff    = div_trial - {1'b0, attack_length_reg};
        div_ge      = div_trial >= {1'b0, attack_length_reg};
        ramp_active = (attack_length_reg != '0) && (ramp_reg < attack_length_reg);
        ramp_sample = cur_reg[SW-1] ? (SW'(0) - quo_reg) : quo_reg;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take && req_valid)
        begin
            noise_reg <= req_noise;
        end
        if (cmd.rd_cur)
        begin
            r_reg  <= r_pos;
            rn_reg <= rn_pos;
        end
        if (cmd.rd_nxt)
        begin
            cur_reg <= ram_rdata;
        end
        if (cmd.mul_ramp)
        begin
            avg_reg <= pair_sum[SW:1];
            rem_reg <= mul_p[27:16];
            quo_reg <= mul_p[SW-1:0];
            cnt_reg <= '0;
        end
        if (cmd.mul_decay)
        begin
            acc_reg <= mul_p[PW-1:16];
        end
        if (cmd.mul_prev)
        begin
            new_reg <= filt_sat;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_diff[TW-1:0] : div_trial[TW-1:0];
            quo_reg <= {quo_reg[SW-2:0], div_ge};
            cnt_reg <= cnt_reg + psv_pkg::DIV_CNT_W'(1);
        end
        if (cmd.finish)
        begin
            out_sample_reg <= ramp_active ? ramp_sample : cur_reg;
        end
    end

    // string state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_pos_reg  <= '0;
            fill_pos_reg  <= '0;
            prev_reg      <= '0;
            ramp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_write)
            begin
                fill_pos_reg <= f_next;
                read_pos_reg <= '0;
                prev_reg     <= '0;
                ramp_reg     <= '0;
            end
            if (cmd.finish)
            begin
                read_pos_reg <= rn_reg;
                prev_reg     <= new_reg;
                if (ramp_active)
                begin
                    ramp_reg <= ramp_reg + TW'(1);
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.req_valid   = req_valid;
        status.req_tick    = (req_operation == psv_pkg::OP_TICK);
        status.ramp_active = ramp_active;
        status.div_last    = (cnt_reg == '1);
        status.out_busy    = out_valid_reg && !out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

endmodule
